@@ design/qau_pkg.sv @@
package qau_pkg;

  // number format
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // first multiply rank: a times b (b widened by one bit for the conjugate)
  localparam int PROD_W     = 2 * DATA_WIDTH + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int LANE_RAW_W = 2 * DATA_WIDTH + 3 - FRAC_BITS;
  localparam int LANE_W     = (LANE_RAW_W > DATA_WIDTH + 1) ? LANE_RAW_W : DATA_WIDTH + 1;

  // second multiply rank: a times t for the rotation
  localparam int RPROD_W    = DATA_WIDTH + LANE_W;
  localparam int RACC_W     = RPROD_W + 2;
  localparam int OUT_RAW_W  = RACC_W - FRAC_BITS + 1;
  localparam int OUT_W      = (OUT_RAW_W > LANE_W + 1) ? OUT_RAW_W : LANE_W + 1;

  // component positions inside a quaternion
  localparam logic [1:0] IDX_W = 2'd0;
  localparam logic [1:0] IDX_X = 2'd1;
  localparam logic [1:0] IDX_Y = 2'd2;
  localparam logic [1:0] IDX_Z = 2'd3;

  typedef enum logic [1:0] {
    FUNC_MUL     = 2'd0,
    FUNC_MULCONJ = 2'd1,
    FUNC_ROTATE  = 2'd2,
    FUNC_RECTIFY = 2'd3
  } func_t;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [3:0][DATA_WIDTH-1:0]   quat_t;
  typedef logic [2:0][DATA_WIDTH-1:0]   vec_t;
  typedef logic [3:0][LANE_W-1:0]       lane_vec_t;
  typedef logic [3:0][OUT_W-1:0]        wide_vec_t;

  typedef struct packed {
    func_t     func;
    quat_t     a;
    vec_t      v;
    lane_vec_t lane;
  } lane_pl_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RACC_W-1:0] RACC_HALF = RACC_W'(1) << (FRAC_BITS - 1);

endpackage

@@ design/qau_in_if.sv @@
interface qau_in_if import qau_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  data_t       a_w;
  data_t       a_x;
  data_t       a_y;
  data_t       a_z;
  data_t       b_w;
  data_t       b_x;
  data_t       b_y;
  data_t       b_z;

  modport source (
    output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    input  ready
  );

  modport sink (
    input  valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
    output ready
  );
endinterface

@@ design/qau_out_if.sv @@
interface qau_out_if import qau_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t r_w;
  data_t r_x;
  data_t r_y;
  data_t r_z;
  logic  saturated;

  modport source (
    output valid, r_w, r_x, r_y, r_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, r_w, r_x, r_y, r_z, saturated,
    output ready
  );
endinterface

@@ design/qau_product.sv @@
module qau_product import qau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  func_t    func,
  input  quat_t    a,
  input  quat_t    b,
  output logic     out_valid,
  input  logic     out_ready,
  output lane_pl_t out_pl
);

  logic signed [DATA_WIDTH:0]  bn [4];
  logic signed [PROD_W-1:0]    prod_next [4][4];

  logic                        s1_valid;
  logic                        s1_ready;
  func_t                       s1_func;
  quat_t                       s1_a;
  vec_t                        s1_v;
  logic signed [PROD_W-1:0]    s1_prod [4][4];

  logic                        s2_ready;
  logic signed [ACC_W-1:0]     acc [4];
  lane_vec_t                   lane_next;
  logic signed [ACC_W-1:0]     rounded;
  logic signed [DATA_WIDTH:0]  a_ext;

  function automatic logic signed [ACC_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return ACC_W'(p);
  endfunction

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // all sixteen a_i * b_j products, b imaginary part negated for the conjugate
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bn[j] = (DATA_WIDTH + 1)'($signed(b[j]));
      if (func == FUNC_MULCONJ && j != 0) begin
        bn[j] = -bn[j];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_next[i][j] = $signed(a[i]) * bn[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_func <= func;
      s1_a    <= a;
      s1_v    <= b[3:1];
      s1_prod <= prod_next;
    end
  end

  // sums of products, then one rounding per component; rectify passes a, negated when a_w < 0
  always_comb begin
    acc[IDX_W] = '0;
    acc[IDX_X] = '0;
    acc[IDX_Y] = '0;
    acc[IDX_Z] = '0;
    unique case (s1_func)
      FUNC_MUL, FUNC_MULCONJ: begin
        acc[IDX_W] = ext(s1_prod[0][0]) - ext(s1_prod[1][1])
                   - ext(s1_prod[2][2]) - ext(s1_prod[3][3]);
        acc[IDX_X] = ext(s1_prod[2][3]) - ext(s1_prod[3][2])
                   + ext(s1_prod[1][0]) + ext(s1_prod[0][1]);
        acc[IDX_Y] = ext(s1_prod[3][1]) - ext(s1_prod[1][3])
                   + ext(s1_prod[2][0]) + ext(s1_prod[0][2]);
        acc[IDX_Z] = ext(s1_prod[1][2]) - ext(s1_prod[2][1])
                   + ext(s1_prod[3][0]) + ext(s1_prod[0][3]);
      end
      FUNC_ROTATE: begin
        // t = 2 (qv x v)
        acc[IDX_X] = (ext(s1_prod[2][3]) - ext(s1_prod[3][2])) <<< 1;
        acc[IDX_Y] = (ext(s1_prod[3][1]) - ext(s1_prod[1][3])) <<< 1;
        acc[IDX_Z] = (ext(s1_prod[1][2]) - ext(s1_prod[2][1])) <<< 1;
      end
      FUNC_RECTIFY: begin
        acc[IDX_W] = '0;
      end
      default: begin
        acc[IDX_W] = '0;
      end
    endcase

    rounded = '0;
    a_ext   = '0;
    for (int k = 0; k < 4; k++) begin
      rounded = (acc[k] + ACC_HALF) >>> FRAC_BITS;
      lane_next[k] = LANE_W'(rounded);
      if (s1_func == FUNC_RECTIFY) begin
        a_ext = (DATA_WIDTH + 1)'($signed(s1_a[k]));
        if (s1_a[IDX_W][DATA_WIDTH-1]) begin
          a_ext = -a_ext;
        end
        lane_next[k] = LANE_W'(a_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_pl.func <= s1_func;
      out_pl.a    <= s1_a;
      out_pl.v    <= s1_v;
      out_pl.lane <= lane_next;
    end
  end

endmodule

@@ design/qau_rotate.sv @@
module qau_rotate import qau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lane_pl_t  in_pl,
  output logic      out_valid,
  input  logic      out_ready,
  output wide_vec_t out_r
);

  logic signed [RPROD_W-1:0] q_next [3][3];

  logic                      s3_valid;
  logic                      s3_ready;
  lane_pl_t                  s3_pl;
  logic signed [RPROD_W-1:0] s3_q [3][3];

  logic                      s4_ready;
  logic signed [RACC_W-1:0]  sum;
  wide_vec_t                 r_next;

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  // row k: a_w t_k + a_next t_prev - a_prev t_next
  always_comb begin
    q_next[0][0] = $signed(in_pl.a[IDX_W]) * $signed(in_pl.lane[IDX_X]);
    q_next[0][1] = $signed(in_pl.a[IDX_Y]) * $signed(in_pl.lane[IDX_Z]);
    q_next[0][2] = $signed(in_pl.a[IDX_Z]) * $signed(in_pl.lane[IDX_Y]);
    q_next[1][0] = $signed(in_pl.a[IDX_W]) * $signed(in_pl.lane[IDX_Y]);
    q_next[1][1] = $signed(in_pl.a[IDX_Z]) * $signed(in_pl.lane[IDX_X]);
    q_next[1][2] = $signed(in_pl.a[IDX_X]) * $signed(in_pl.lane[IDX_Z]);
    q_next[2][0] = $signed(in_pl.a[IDX_W]) * $signed(in_pl.lane[IDX_Z]);
    q_next[2][1] = $signed(in_pl.a[IDX_X]) * $signed(in_pl.lane[IDX_Y]);
    q_next[2][2] = $signed(in_pl.a[IDX_Y]) * $signed(in_pl.lane[IDX_X]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_pl <= in_pl;
      s3_q  <= q_next;
    end
  end

  // v + rnd(...) for rotate, other operations pass their lanes
  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      r_next[k] = OUT_W'($signed(s3_pl.lane[k]));
    end
    if (s3_pl.func == FUNC_ROTATE) begin
      r_next[IDX_W] = '0;
      for (int k = 0; k < 3; k++) begin
        sum = RACC_W'(s3_q[k][0]) + RACC_W'(s3_q[k][1]) - RACC_W'(s3_q[k][2]) + RACC_HALF;
        r_next[k+1] = OUT_W'(sum >>> FRAC_BITS) + OUT_W'($signed(s3_pl.v[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      out_r <= r_next;
    end
  end

endmodule

@@ design/qau_clip.sv @@
module qau_clip import qau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  wide_vec_t in_r,
  output logic      out_valid,
  input  logic      out_ready,
  output quat_t     out_r,
  output logic      out_sat
);

  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(DATA_MAX);
  localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(DATA_MIN);

  logic signed [OUT_W-1:0] val;
  quat_t                   r_next;
  logic                    sat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    val      = '0;
    sat_next = 1'b0;
    for (int k = 0; k < 4; k++) begin
      val = $signed(in_r[k]);
      if (val > OUT_MAX) begin
        r_next[k] = DATA_MAX;
        sat_next  = 1'b1;
      end else if (val < OUT_MIN) begin
        r_next[k] = DATA_MIN;
        sat_next  = 1'b1;
      end else begin
        r_next[k] = DATA_WIDTH'(val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_r   <= r_next;
      out_sat <= sat_next;
    end
  end

endmodule

@@ design/quaternion_arithmetic_unit_top.sv @@
// Quaternion arithmetic unit, signed Q1.14 in 16 bits (16384 = 1.0). Each operand
// transaction carries quaternions a and b and func: multiply a*b, multiply a*conj(b),
// rotate the vector (b_x, b_y, b_z) by a, or rectify a (negate when a_w < 0). Every
// sum of products is rounded once, half up, then each result component is clipped to
// 16 bits and saturated flags any clip; r_w is zero for rotate. The unit takes one
// transaction per clock unless the result side stalls, and returns one result per
// transaction, in order, through first multiply rank, sum/round, second multiply rank
// for the rotation, sum/round and clip/output register. Every stage holds its own
// valid, so a stalled result only stops the stages behind it; bubbles are squeezed
// out and the operand side keeps taking transactions until the pipeline is full.
module quaternion_arithmetic_unit_top import qau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  qau_in_if.sink    operand,
  qau_out_if.source result
);

  // first rank: products and rounded sums (quaternion product or t vector)
  logic      lane_valid;
  logic      lane_ready;
  lane_pl_t  lane_pl;

  // second rank: rotation products and v + rnd(...)
  logic      wide_valid;
  logic      wide_ready;
  wide_vec_t wide_r;

  quat_t     r_q;

  qau_product u_product (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .func      (func_t'(operand.func)),
    .a         ({operand.a_z, operand.a_y, operand.a_x, operand.a_w}),
    .b         ({operand.b_z, operand.b_y, operand.b_x, operand.b_w}),
    .out_valid (lane_valid),
    .out_ready (lane_ready),
    .out_pl    (lane_pl)
  );

  qau_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lane_valid),
    .in_ready  (lane_ready),
    .in_pl     (lane_pl),
    .out_valid (wide_valid),
    .out_ready (wide_ready),
    .out_r     (wide_r)
  );

  // clip to 16 bits and hold the result transaction for the sink
  qau_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wide_valid),
    .in_ready  (wide_ready),
    .in_r      (wide_r),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_r     (r_q),
    .out_sat   (result.saturated)
  );

  assign result.r_w = r_q[IDX_W];
  assign result.r_x = r_q[IDX_X];
  assign result.r_y = r_q[IDX_Y];
  assign result.r_z = r_q[IDX_Z];

`ifndef SYNTHESIS
  // a saturated result has at least one component sitting on a limit
  a_sat_on_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      (result.r_w == DATA_MAX) || (result.r_w == DATA_MIN) ||
      (result.r_x == DATA_MAX) || (result.r_x == DATA_MIN) ||
      (result.r_y == DATA_MAX) || (result.r_y == DATA_MIN) ||
      (result.r_z == DATA_MAX) || (result.r_z == DATA_MIN))
    else $error("saturated flag without a clipped component");

  // with the output register empty nothing can hold the operand side back
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> operand.ready)
    else $error("operand stalled while output register is empty");

  // a stalled middle stage keeps its transaction
  a_mid_kept: assert property (@(posedge clk) disable iff (rst)
    wide_valid && !wide_ready |=> wide_valid)
    else $error("rotation stage dropped a stalled transaction");
`endif

endmodule
